// ----- sv/rdp_pkg.sv -----
package rdp_pkg;

   localparam int MAX_PULSES   = 15;
   localparam int PCNT_W       = $clog2(MAX_PULSES + 1);
   localparam int STABLE_W     = 9;
   localparam int DEBOUNCE_W   = 8;
   localparam int DIGIT_W      = 4;
   localparam int ZERO_PULSES  = 10;
   localparam int DIGIT_MAX    = 15;

   localparam logic [STABLE_W-1:0]   STABLE_MAX     = {STABLE_W{1'b1}};
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(5);

   typedef struct packed {
      logic                  prev_raw;
      logic                  accepted;
      logic [STABLE_W-1:0]   stable_time;
      logic [PCNT_W-1:0]     pulse_count;
      logic                  spin_active;
   } rdp_state_type;

   typedef struct packed {
      logic                  ms_tick;
      logic                  dial_turning;
      logic                  pulse_level;
   } rdp_sample_type;

   typedef struct packed {
      logic                  valid;
      logic [DIGIT_W-1:0]    digit;
      logic                  too_many_pulses;
   } rdp_result_type;

   localparam rdp_state_type STATE_RESET = '{
      prev_raw:    1'b1,
      accepted:    1'b0,
      stable_time: STABLE_MAX,
      pulse_count: '0,
      spin_active: 1'b0
   };

endpackage

// ----- sv/rdp_step.sv -----
module rdp_step
   import rdp_pkg::*;
(
   input  rdp_state_type            state_cur,
   input  rdp_sample_type           sample,
   input  logic [DEBOUNCE_W-1:0]    debounce_ms,
   output rdp_state_type            state_nxt,
   output rdp_result_type           result
);

   always_comb begin
      state_nxt              = state_cur;
      result.valid           = 1'b0;
      result.digit           = '0;
      result.too_many_pulses = 1'b0;

      if (sample.dial_turning) begin
         // new spin: timer taken as expired, debounced level low
         if (!state_cur.spin_active) begin
            state_nxt.spin_active = 1'b1;
            state_nxt.pulse_count = '0;
            state_nxt.accepted    = 1'b0;
            state_nxt.stable_time = STABLE_MAX;
         end
         if (sample.pulse_level != state_cur.prev_raw) begin
            state_nxt.stable_time = '0;
         end else if (sample.ms_tick && state_nxt.stable_time != STABLE_MAX) begin
            state_nxt.stable_time = state_nxt.stable_time + STABLE_W'(1);
         end
         if (state_nxt.stable_time > STABLE_W'(debounce_ms) &&
             state_nxt.accepted != sample.pulse_level) begin
            state_nxt.accepted = sample.pulse_level;
            if (sample.pulse_level &&
                state_nxt.pulse_count < PCNT_W'(MAX_PULSES)) begin
               state_nxt.pulse_count = state_nxt.pulse_count + PCNT_W'(1);
            end
         end
         state_nxt.prev_raw = sample.pulse_level;
      end else if (state_cur.spin_active) begin
         state_nxt.spin_active = 1'b0;
         state_nxt.pulse_count = '0;
         if (state_cur.pulse_count != '0) begin
            result.valid = 1'b1;
            if (state_cur.pulse_count == PCNT_W'(ZERO_PULSES)) begin
               result.digit = '0;
            end else if (32'(state_cur.pulse_count) > DIGIT_MAX) begin
               result.digit = DIGIT_W'(DIGIT_MAX);
            end else begin
               result.digit = DIGIT_W'(state_cur.pulse_count);
            end
            result.too_many_pulses = state_cur.pulse_count > PCNT_W'(ZERO_PULSES);
         end
      end
   end

endmodule

// ----- sv/rotary_dial_pulse_decoder_core.sv -----
// Rotary dial pulse decoder. Each req item is one sample of the off-normal
// contact, the raw pulse contact and a millisecond tick. While the dial is
// off normal the pulse level is debounced against csr_debounce_ms (the level
// must stay unchanged for more than that many ticks) and each accepted rising
// level counts one pulse, saturating at 15. When the dial returns home after
// a spin with a nonzero count, one rsp item carries the digit (ten pulses
// give 0) and a flag for more than ten pulses. A sample is registered on
// acceptance and processed into the state and the result register once the
// result register has room, so one item per clock is taken as long as rsp
// is not stalled, and each result is shown on rsp from the result register.
// Write the debounce register only while no items are in flight.
module rotary_dial_pulse_decoder_core
   import rdp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_ms_tick,
   input  logic                    req_dial_turning,
   input  logic                    req_pulse_level,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DIGIT_W-1:0]      rsp_digit,
   output logic                    rsp_too_many_pulses,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [DEBOUNCE_W-1:0]   csr_debounce_ms
);

   logic                    in_valid_ff, in_valid_in;
   rdp_sample_type          sample_ff, sample_in;
   rdp_state_type           state_ff, state_in;
   logic                    out_valid_ff, out_valid_in;
   logic [DIGIT_W-1:0]      digit_ff, digit_in;
   logic                    too_many_ff, too_many_in;
   logic [DEBOUNCE_W-1:0]   debounce_ff, debounce_in;

   rdp_state_type           state_nxt;
   rdp_result_type          result;
   logic                    fire;

   rdp_step u_step (
      .state_cur   (state_ff),
      .sample      (sample_ff),
      .debounce_ms (debounce_ff),
      .state_nxt   (state_nxt),
      .result      (result)
   );

   // process the held item once the result register has room
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      sample_in   = sample_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in            = 1'b1;
         sample_in.ms_tick      = req_ms_tick;
         sample_in.dial_turning = req_dial_turning;
         sample_in.pulse_level  = req_pulse_level;
      end

      state_in = fire ? state_nxt : state_ff;

      out_valid_in = out_valid_ff;
      digit_in     = digit_ff;
      too_many_in  = too_many_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire && result.valid) begin
         out_valid_in = 1'b1;
         digit_in     = result.digit;
         too_many_in  = result.too_many_pulses;
      end

      debounce_in = (csr_valid && csr_ready) ? csr_debounce_ms : debounce_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
         debounce_ff  <= DEBOUNCE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         debounce_ff  <= debounce_in;
      end
      sample_ff   <= sample_in;
      digit_ff    <= digit_in;
      too_many_ff <= too_many_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_digit           = digit_ff;
   assign rsp_too_many_pulses = too_many_ff;

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.spin_active |-> state_ff.pulse_count == '0)
      else $error("pulse count nonzero outside a spin");

   a_result_ends_spin: assert property (@(posedge clock) disable iff (reset)
      fire && result.valid |=> !state_ff.spin_active)
      else $error("result issued while spin still active");

   a_too_many_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_many_pulses |-> rsp_digit > DIGIT_W'(ZERO_PULSES))
      else $error("too-many flag with digit of ten or less");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(sample_ff))
      else $error("held item lost before processing");

endmodule

// ----- verif/tb_rotary_dial_pulse_decoder_core.sv -----
`timescale 1ns / 1ps

module tb_rotary_dial_pulse_decoder_core;
   import rdp_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_ms_tick = 1'b0;
   logic                  req_dial_turning = 1'b0;
   logic                  req_pulse_level = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DIGIT_W-1:0]    rsp_digit;
   logic                  rsp_too_many_pulses;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [DEBOUNCE_W-1:0] csr_debounce_ms = '0;

   // predicted decoder state and the digits it still owes
   rdp_state_type         dial_st;
   logic [DEBOUNCE_W-1:0] debounce_cfg;
   rdp_result_type        dialed_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rx_hold_req = 0;
   int rx_hold_left = 0;
   int items_sent = 0;
   int digits_predicted = 0;
   int mismatches = 0;
   int unsigned cycle_count = 0;

   rotary_dial_pulse_decoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_ms_tick         (req_ms_tick),
      .req_dial_turning    (req_dial_turning),
      .req_pulse_level     (req_pulse_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit           (rsp_digit),
      .rsp_too_many_pulses (rsp_too_many_pulses),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_debounce_ms     (csr_debounce_ms)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rotary_dial_pulse_decoder_core verification failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (rx_hold_req > 0) begin
         rx_hold_left = rx_hold_req;
         rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rdp_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (dialed_q.size() == 0) begin
            $display("%0t: unexpected digit, expected none, got digit %0d too_many %0b",
                     $time, rsp_digit, rsp_too_many_pulses);
            mismatches++;
         end else begin
            want = dialed_q.pop_front();
            if (rsp_digit !== want.digit) begin
               $display("%0t: digit mismatch, expected %0d, got %0d",
                        $time, want.digit, rsp_digit);
               mismatches++;
            end
            if (rsp_too_many_pulses !== want.too_many_pulses) begin
               $display("%0t: too_many_pulses mismatch, expected %0b, got %0b",
                        $time, want.too_many_pulses, rsp_too_many_pulses);
               mismatches++;
            end
         end
      end
   end

   task automatic decode_sample(input logic tick, input logic turning, input logic level);
      rdp_result_type r;
      if (turning) begin
         if (!dial_st.spin_active) begin
            dial_st.spin_active = 1'b1;
            dial_st.pulse_count = '0;
            dial_st.accepted    = 1'b0;
            dial_st.stable_time = STABLE_MAX;
         end
         // a change wins over a tick in the same sample
         if (level != dial_st.prev_raw)
            dial_st.stable_time = '0;
         else if (tick && dial_st.stable_time != STABLE_MAX)
            dial_st.stable_time = dial_st.stable_time + 1'b1;
         if (dial_st.stable_time > debounce_cfg && dial_st.accepted != level) begin
            dial_st.accepted = level;
            if (level && dial_st.pulse_count < MAX_PULSES)
               dial_st.pulse_count = dial_st.pulse_count + 1'b1;
         end
         dial_st.prev_raw = level;
      end else if (dial_st.spin_active) begin
         dial_st.spin_active = 1'b0;
         if (dial_st.pulse_count != 0) begin
            r.valid = 1'b1;
            if (dial_st.pulse_count == ZERO_PULSES)
               r.digit = '0;
            else if (dial_st.pulse_count > DIGIT_MAX)
               r.digit = DIGIT_W'(DIGIT_MAX);
            else
               r.digit = DIGIT_W'(dial_st.pulse_count);
            r.too_many_pulses = (dial_st.pulse_count > ZERO_PULSES);
            dialed_q.push_back(r);
            digits_predicted++;
         end
         dial_st.pulse_count = '0;
      end
   endtask

   task automatic offer_sample(input logic tick, input logic turning, input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ms_tick      <= tick;
      req_dial_turning <= turning;
      req_pulse_level  <= level;
      do @(posedge clock); while (!req_ready);
      decode_sample(tick, turning, level);
      items_sent++;
   endtask

   // wait for every owed digit plus the pipeline tail
   task automatic settle();
      req_valid <= 1'b0;
      while (dialed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
      settle();
      csr_valid       <= 1'b1;
      csr_debounce_ms <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      debounce_cfg = value;
   endtask

   // off-normal contact open, pulse contact at one level for a number of ticks
   task automatic hold_contact(input logic level, input int ticks);
      int i;
      offer_sample(1'($urandom_range(1)), 1'b1, level);
      for (i = 0; i < ticks; i++) begin
         if ($urandom_range(3) == 0)
            offer_sample(1'b0, 1'b1, level);
         offer_sample(1'b1, 1'b1, level);
      end
   endtask

   task automatic dial_spin(input int pulses, input int slack);
      int i;
      int need;
      need = int'(debounce_cfg) + 1;
      repeat ($urandom_range(2))
         offer_sample(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)));
      for (i = 0; i < pulses; i++) begin
         // short bounce that must not count
         if ($urandom_range(5) == 0)
            hold_contact(1'b1, $urandom_range(need - 1));
         hold_contact(1'b0, need + $urandom_range(slack));
         hold_contact(1'b1, need + $urandom_range(slack));
      end
      hold_contact(1'b0, need);
      offer_sample(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)));
   endtask

   task automatic test_reset_debounce();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // five ticks is not more than five: no pulse
      hold_contact(1'b0, 6);
      hold_contact(1'b1, 5);
      hold_contact(1'b0, 6);
      hold_contact(1'b1, 6);
      hold_contact(1'b0, 6);
      offer_sample(1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_pulse_counts();
      int i;
      write_debounce(8'd0);
      // at rest outside a spin nothing happens
      for (i = 0; i < 4; i++)
         offer_sample(i[0], 1'b0, i[1]);
      // spin with no pulse gives no digit
      hold_contact(1'b0, 2);
      offer_sample(1'b1, 1'b0, 1'b1);
      // spin left high, next spin starts high with an expired timer
      hold_contact(1'b1, 2);
      offer_sample(1'b0, 1'b0, 1'b0);
      offer_sample(1'b0, 1'b1, 1'b1);
      offer_sample(1'b1, 1'b0, 1'b1);
      // change together with tick
      offer_sample(1'b1, 1'b1, 1'b0);
      offer_sample(1'b1, 1'b1, 1'b1);
      offer_sample(1'b1, 1'b1, 1'b1);
      offer_sample(1'b1, 1'b0, 1'b0);
      dial_spin(1, 0);
      dial_spin(10, 0);
      dial_spin(11, 0);
      dial_spin(17, 0);
   endtask

   task automatic test_long_debounce();
      int i;
      write_debounce(8'd255);
      // 255 quiet ticks after the rise do not accept it, the next one does
      offer_sample(1'b1, 1'b1, 1'b0);
      for (i = 0; i < 257; i++)
         offer_sample(1'b1, 1'b1, 1'b1);
      hold_contact(1'b0, 2);
      offer_sample(1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_random_spins(input int send_pct, input int recv_pct,
                                    input logic [DEBOUNCE_W-1:0] db);
      int first_item;
      int first_digit;
      write_debounce(db);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first_item = items_sent;
      first_digit = digits_predicted;
      while (items_sent - first_item < 50 || digits_predicted - first_digit < 3) begin
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(7) == 0)
               dial_spin($urandom_range(18), 2);
            else
               dial_spin($urandom_range(4), 2);
         end else begin
            repeat ($urandom_range(1, 20))
               offer_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
         end
      end
   endtask

   task automatic test_output_stall();
      write_debounce(8'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rx_hold_req = 400;
      repeat (6) dial_spin(1 + $urandom_range(2), 0);
      // hold the sender until the backlog has drained
      settle();
      repeat (2) dial_spin(1 + $urandom_range(3), 1);
   endtask

   initial begin
      dial_st = STATE_RESET;
      debounce_cfg = DEBOUNCE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_debounce();
      test_pulse_counts();
      test_long_debounce();
      test_random_spins(20, 74, 8'd1);
      test_random_spins(74, 20, DEBOUNCE_W'($urandom_range(2, 4)));
      test_random_spins(0, 0, 8'd0);
      test_output_stall();
      settle();
      if (mismatches == 0 && dialed_q.size() == 0) begin
         $display("rotary_dial_pulse_decoder_core verification clean");
      end else begin
         $display("rotary_dial_pulse_decoder_core verification failed");
      end
      $finish;
   end

endmodule
